// ----- hw/rtl/tkp_pkg.sv -----
// shared types and constants of the three-key pad
package tkp_pkg;

    localparam int TIME_W = 32;
    localparam int CFG_W  = 16;
    localparam int VOL_W  = 3;
    localparam int IDX_W  = 2;

    // register indexes of the configuration port
    localparam logic [IDX_W-1:0] CFG_SHORT_PRESS = 2'd0;
    localparam logic [IDX_W-1:0] CFG_DOUBLE_CLK  = 2'd1;
    localparam logic [IDX_W-1:0] CFG_BEEP_LEN    = 2'd2;
    localparam logic [IDX_W-1:0] CFG_BEEP_VOL    = 2'd3;

    localparam logic [CFG_W-1:0] RST_SHORT_PRESS = 16'd10;
    localparam logic [CFG_W-1:0] RST_DOUBLE_CLK  = 16'd450;
    localparam logic [CFG_W-1:0] RST_BEEP_LEN    = 16'd50;
    localparam logic [VOL_W-1:0] RST_BEEP_VOL    = 3'd3;

    // key codes
    localparam logic [1:0] KEY_NONE  = 2'd0;
    localparam logic [1:0] KEY_NEXT  = 2'd1;
    localparam logic [1:0] KEY_PREV  = 2'd2;
    localparam logic [1:0] KEY_ENTER = 2'd3;

    localparam logic [VOL_W-1:0] VOL_MIN = 3'd1;
    localparam logic [VOL_W-1:0] VOL_MAX = 3'd4;

    typedef struct packed {
        logic [CFG_W-1:0] short_press_ms;
        logic [CFG_W-1:0] double_click_ms;
        logic [CFG_W-1:0] beep_length_ms;
        logic [VOL_W-1:0] beep_volume;
    } t_cfg;

    typedef struct packed {
        logic              key_pressed;
        logic [1:0]        key_code;
        logic              back_event;
        logic [VOL_W-1:0]  buzzer_drive;
    } t_res;

endpackage

// ----- hw/rtl/tkp_cfg.sv -----
// configuration registers of the three-key pad
module tkp_cfg
    import tkp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_W-1:0]  i_cfg_data,
    output t_cfg              o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SHORT_PRESS: n_cfg.short_press_ms  = i_cfg_data;
                CFG_DOUBLE_CLK:  n_cfg.double_click_ms = i_cfg_data;
                CFG_BEEP_LEN:    n_cfg.beep_length_ms  = i_cfg_data;
                CFG_BEEP_VOL:    n_cfg.beep_volume     = i_cfg_data[VOL_W-1:0];
                default:         n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.short_press_ms  <= RST_SHORT_PRESS;
            r_cfg.double_click_ms <= RST_DOUBLE_CLK;
            r_cfg.beep_length_ms  <= RST_BEEP_LEN;
            r_cfg.beep_volume     <= RST_BEEP_VOL;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- hw/rtl/tkp_core.sv -----
// key, click and beep state with the per-poll update logic
module tkp_core
    import tkp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic              i_right_low,
    input  logic              i_left_low,
    input  logic              i_push_low,
    input  logic [TIME_W-1:0] i_now_ms,
    input  t_cfg              i_cfg,
    output t_res              o_res
);

    logic [1:0]        r_held_key,   n_held_key;
    logic              r_push_held,  n_push_held;
    logic [TIME_W-1:0] r_push_start, n_push_start;
    logic [TIME_W-1:0] r_last_click, n_last_click;
    logic [1:0]        r_prev_key,   n_prev_key;
    logic              r_beeping,    n_beeping;
    logic [TIME_W-1:0] r_beep_start, n_beep_start;

    logic [1:0]        poll_key;
    logic              is_click;
    logic              is_double;
    logic              beep_req;
    logic [TIME_W-1:0] held_time;
    logic [TIME_W-1:0] click_gap;
    logic [TIME_W-1:0] beep_time;
    logic [VOL_W-1:0]  level;

    assign held_time = i_now_ms - r_push_start;
    assign click_gap = i_now_ms - r_last_click;

    always_comb begin
        n_push_held  = r_push_held;
        n_push_start = r_push_start;
        n_last_click = r_last_click;
        is_click     = 1'b0;
        is_double    = 1'b0;
        if (i_right_low) begin
            poll_key = KEY_NEXT;
        end else if (i_left_low) begin
            poll_key = KEY_PREV;
        end else if (i_push_low) begin
            poll_key = KEY_ENTER;
            if (!r_push_held) begin
                n_push_held  = 1'b1;
                n_push_start = i_now_ms;
            end
        end else begin
            poll_key    = KEY_NONE;
            is_click    = r_push_held &&
                          (held_time >= {{(TIME_W-CFG_W){1'b0}}, i_cfg.short_press_ms});
            n_push_held = 1'b0;
            if (is_click) begin
                // a stored time of zero reads as no click
                if ((r_last_click != '0) &&
                    (click_gap <= {{(TIME_W-CFG_W){1'b0}}, i_cfg.double_click_ms})) begin
                    is_double    = 1'b1;
                    n_last_click = '0;
                end else begin
                    n_last_click = i_now_ms;
                end
            end
        end
    end

    always_comb begin
        n_held_key = (poll_key != KEY_NONE) ? poll_key : r_held_key;
        n_prev_key = poll_key;
        beep_req   = is_double || ((poll_key != KEY_NONE) && (poll_key != r_prev_key));
        // a running beep keeps its start time
        n_beep_start = r_beeping ? r_beep_start : i_now_ms;
        beep_time    = i_now_ms - n_beep_start;
        n_beeping    = (r_beeping || beep_req) &&
                       (beep_time < {{(TIME_W-CFG_W){1'b0}}, i_cfg.beep_length_ms});
    end

    always_comb begin
        if (i_cfg.beep_volume < VOL_MIN) begin
            level = VOL_MIN;
        end else if (i_cfg.beep_volume > VOL_MAX) begin
            level = VOL_MAX;
        end else begin
            level = i_cfg.beep_volume;
        end
    end

    always_comb begin
        o_res.key_pressed  = (poll_key != KEY_NONE);
        o_res.key_code     = n_held_key;
        o_res.back_event   = is_double;
        o_res.buzzer_drive = n_beeping ? level : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_key   <= KEY_NONE;
            r_push_held  <= 1'b0;
            r_push_start <= '0;
            r_last_click <= '0;
            r_prev_key   <= KEY_NONE;
            r_beeping    <= 1'b0;
            r_beep_start <= '0;
        end else if (i_step) begin
            r_held_key   <= n_held_key;
            r_push_held  <= n_push_held;
            r_push_start <= n_push_start;
            r_last_click <= n_last_click;
            r_prev_key   <= n_prev_key;
            r_beeping    <= n_beeping;
            r_beep_start <= n_beep_start;
        end
    end

endmodule

// ----- hw/rtl/three_key_pad_with_double_click.sv -----
// a poll's result passes through the input register and then the result register on its way to the outputs
// throughput: one poll per cycle while results are taken; a held result stalls only when both stages are full
// each poll updates the key, click and beep state as it leaves the input stage
// reset (synchronous, active low) empties both stages, clears the key, click and beep state to zero and loads
// the configuration defaults: short press 10, double click 450, beep length 50, volume 3
module three_key_pad_with_double_click
    import tkp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic              i_right_low,
    input  logic              i_left_low,
    input  logic              i_push_low,
    input  logic [TIME_W-1:0] i_now_ms,
    output logic              o_valid,
    input  logic              i_ready,
    output logic              o_key_pressed,
    output logic [1:0]        o_key_code,
    output logic              o_back_event,
    output logic [VOL_W-1:0]  o_buzzer_drive,
    input  logic              i_cfg_we,
    input  logic [IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_W-1:0]  i_cfg_data
);

    logic              r_in_valid;
    logic              r_right, r_left, r_push;
    logic [TIME_W-1:0] r_now;
    logic              r_out_valid;
    t_res              r_res;

    logic out_free;
    logic step;
    t_cfg cfg;
    t_res res;

    assign out_free = !r_out_valid || i_ready;
    assign step     = r_in_valid && out_free;
    assign o_ready  = !r_in_valid || out_free;

    tkp_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    tkp_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_right_low (r_right),
        .i_left_low  (r_left),
        .i_push_low  (r_push),
        .i_now_ms    (r_now),
        .i_cfg       (cfg),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_right <= i_right_low;
            r_left  <= i_left_low;
            r_push  <= i_push_low;
            r_now   <= i_now_ms;
        end
        if (step) begin
            r_res <= res;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_key_pressed  = r_res.key_pressed;
    assign o_key_code     = r_res.key_code;
    assign o_back_event   = r_res.back_event;
    assign o_buzzer_drive = r_res.buzzer_drive;

endmodule

// ----- hw/rtl/tkp_checker.sv -----
// port-level checks of the three-key pad and their binding
module tkp_checker
    import tkp_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             o_valid,
    input logic             i_ready,
    input logic             o_key_pressed,
    input logic [1:0]       o_key_code,
    input logic             o_back_event,
    input logic [VOL_W-1:0] o_buzzer_drive
);

    // no result survives a reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    // a held key always leaves a key code behind
    a_pressed_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_key_pressed) |-> (o_key_code != KEY_NONE))
        else $error("key held but key code is none");

    // a double click completes on a release, so no key is held
    a_back_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_back_event) |-> !o_key_pressed)
        else $error("back event without a push release");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_key_code) &&
                                   $stable(o_buzzer_drive) && $stable(o_back_event)))
        else $error("result changed while stalled");

endmodule

bind three_key_pad_with_double_click tkp_checker u_tkp_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_key_pressed  (o_key_pressed),
    .o_key_code     (o_key_code),
    .o_back_event   (o_back_event),
    .o_buzzer_drive (o_buzzer_drive)
);

// ----- sim/tb_three_key_pad_with_double_click.sv -----
`timescale 1ns / 1ps
// self-checking bench for the three-key pad: directed poll table, then random register phases

module tb_three_key_pad_with_double_click;
    import tkp_pkg::*;

    typedef enum logic {ROW_POLL, ROW_CFG} t_row_kind;

    typedef struct {
        t_row_kind         kind;
        logic              right;
        logic              left;
        logic              push;
        logic [TIME_W-1:0] value;   // poll time, or register data
        logic [IDX_W-1:0]  idx;
        logic              typed;
        t_res              want;
    } t_pad_row;

    typedef struct {
        logic [1:0]        held_key;
        logic              push_held;
        logic [TIME_W-1:0] push_start;
        logic [TIME_W-1:0] last_click;
        logic [1:0]        prev_key;
        logic              beeping;
        logic [TIME_W-1:0] beep_start;
    } t_pad_state;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic              o_ready;
    logic              i_right_low = 1'b0;
    logic              i_left_low = 1'b0;
    logic              i_push_low = 1'b0;
    logic [TIME_W-1:0] i_now_ms = '0;
    logic              o_valid;
    logic              i_ready = 1'b0;
    logic              o_key_pressed;
    logic [1:0]        o_key_code;
    logic              o_back_event;
    logic [VOL_W-1:0]  o_buzzer_drive;
    logic              i_cfg_we = 1'b0;
    logic [IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_W-1:0]  i_cfg_data = '0;

    three_key_pad_with_double_click u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_right_low    (i_right_low),
        .i_left_low     (i_left_low),
        .i_push_low     (i_push_low),
        .i_now_ms       (i_now_ms),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_key_pressed  (o_key_pressed),
        .o_key_code     (o_key_code),
        .o_back_event   (o_back_event),
        .o_buzzer_drive (o_buzzer_drive),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    t_cfg       pad_cfg;
    t_pad_state pad;
    t_res       pad_results_due[$];
    int         n_fail = 0;
    int         n_polls = 0;
    int         n_reports = 0;
    int         n_back = 0;
    int         n_beep = 0;
    int         n_settings = 0;
    int         stall_left = 0;

    function automatic void begin_beep(input logic [TIME_W-1:0] now);
        if (!pad.beeping) begin
            pad.beeping = 1'b1;
            pad.beep_start = now;
        end
    endfunction

    // one poll of the pad: updates the key, click and beep state
    function automatic t_res next_pad_result(input logic right, input logic left,
                                             input logic push, input logic [TIME_W-1:0] now);
        t_res              res;
        logic [1:0]        key;
        logic [TIME_W-1:0] span;
        logic [VOL_W-1:0]  level;
        res = '0;
        if (right) begin
            key = KEY_NEXT;
        end else if (left) begin
            key = KEY_PREV;
        end else if (push) begin
            if (!pad.push_held) begin
                pad.push_held = 1'b1;
                pad.push_start = now;
            end
            key = KEY_ENTER;
        end else begin
            key = KEY_NONE;
            span = now - pad.push_start;
            if (pad.push_held && span >= TIME_W'(pad_cfg.short_press_ms)) begin
                span = now - pad.last_click;
                if (pad.last_click != '0 && span <= TIME_W'(pad_cfg.double_click_ms)) begin
                    begin_beep(now);
                    res.back_event = 1'b1;
                    pad.last_click = '0;
                end else begin
                    // a release at time zero is stored as zero, i.e. no click
                    pad.last_click = now;
                end
            end
            pad.push_held = 1'b0;
        end

        if (key != KEY_NONE) begin
            res.key_pressed = 1'b1;
            pad.held_key = key;
            if (key != pad.prev_key) begin_beep(now);
            pad.prev_key = key;
        end else begin
            pad.prev_key = KEY_NONE;
        end

        span = now - pad.beep_start;
        if (pad.beeping && span >= TIME_W'(pad_cfg.beep_length_ms)) pad.beeping = 1'b0;

        if (pad_cfg.beep_volume < VOL_MIN) begin
            level = VOL_MIN;
        end else if (pad_cfg.beep_volume > VOL_MAX) begin
            level = VOL_MAX;
        end else begin
            level = pad_cfg.beep_volume;
        end
        res.key_code = pad.held_key;
        res.buzzer_drive = pad.beeping ? level : '0;
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        if (n_fail < 40) $display("[%0t] mismatch: %s", $time, msg);
        n_fail++;
    endtask

    // result side: check every transfer against the oldest expectation
    always @(posedge i_clk) begin : check_results
        t_res want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pad_results_due.size() == 0) begin
                report_mismatch($sformatf("result %0d arrived with nothing expected", n_reports));
            end else begin
                want = pad_results_due.pop_front();
                if (want.back_event) n_back++;
                if (want.buzzer_drive != '0) n_beep++;
                if (o_key_pressed !== want.key_pressed)
                    report_mismatch($sformatf("result %0d key_pressed got %0d want %0d",
                                              n_reports, o_key_pressed, want.key_pressed));
                if (o_key_code !== want.key_code)
                    report_mismatch($sformatf("result %0d key_code got %0d want %0d",
                                              n_reports, o_key_code, want.key_code));
                if (o_back_event !== want.back_event)
                    report_mismatch($sformatf("result %0d back_event got %0d want %0d",
                                              n_reports, o_back_event, want.back_event));
                if (o_buzzer_drive !== want.buzzer_drive)
                    report_mismatch($sformatf("result %0d buzzer_drive got %0d want %0d",
                                              n_reports, o_buzzer_drive, want.buzzer_drive));
            end
            n_reports++;
            // every fourth stretch of results runs without stalls
            stall_left = ((n_reports / 24) % 4 == 1) ? 0 : $urandom_range(0, 8);
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (stall_left > 0) begin
            i_ready <= 1'b0;
            stall_left--;
        end else begin
            i_ready <= 1'b1;
        end
    end

    task automatic send_poll(input logic right, input logic left, input logic push,
                             input logic [TIME_W-1:0] now, input logic typed, input t_res want);
        int   gap;
        t_res predicted;
        gap = ((n_polls / 24) % 4 == 3) ? 0 : $urandom_range(0, 8);
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid     <= 1'b1;
        i_right_low <= right;
        i_left_low  <= left;
        i_push_low  <= push;
        i_now_ms    <= now;
        do @(posedge i_clk); while (!o_ready);
        predicted = next_pad_result(right, left, push, now);
        pad_results_due.push_back(typed ? want : predicted);
        n_polls++;
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pad_results_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        drain_results();
        // both stages emptied once the last result is out; a little margin anyway
        repeat (4) @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_SHORT_PRESS: pad_cfg.short_press_ms = data;
            CFG_DOUBLE_CLK:  pad_cfg.double_click_ms = data;
            CFG_BEEP_LEN:    pad_cfg.beep_length_ms = data;
            CFG_BEEP_VOL:    pad_cfg.beep_volume = data[VOL_W-1:0];
            default: ;
        endcase
    endtask

    // random polls under one register setting; key patterns tend to persist so holds form
    task automatic run_phase(input logic [CFG_W-1:0] short_ms, input logic [CFG_W-1:0] dbl_ms,
                             input logic [CFG_W-1:0] len_ms, input logic [CFG_W-1:0] vol,
                             input int step_max, input logic [TIME_W-1:0] start, input int pause_at);
        logic [2:0]        keys;
        logic [TIME_W-1:0] now;
        int                pick;
        write_reg(CFG_SHORT_PRESS, short_ms);
        write_reg(CFG_DOUBLE_CLK, dbl_ms);
        write_reg(CFG_BEEP_LEN, len_ms);
        write_reg(CFG_BEEP_VOL, vol);
        n_settings++;
        keys = 3'b000;
        now = start;
        for (int k = 0; k < 100; k++) begin
            if (k == pause_at) drain_results();
            if ($urandom_range(0, 9) >= 4) begin
                pick = $urandom_range(0, 19);
                if (pick < 9)       keys = 3'b001;
                else if (pick < 15) keys = 3'b000;
                else if (pick < 17) keys = {1'b1, 2'($urandom_range(0, 3))};
                else if (pick < 19) keys = {2'b01, 1'($urandom_range(0, 1))};
                else                keys = 3'($urandom_range(0, 7));
            end
            if ($urandom_range(0, 31) == 0) now = $urandom;
            else now = now + TIME_W'($urandom_range(0, step_max));
            send_poll(keys[2], keys[1], keys[0], now, 1'b0, '0);
        end
    endtask

    function automatic t_pad_row poll_row(input logic right, input logic left, input logic push,
                                          input logic [TIME_W-1:0] now);
        t_pad_row row;
        row.kind  = ROW_POLL;
        row.right = right;
        row.left  = left;
        row.push  = push;
        row.value = now;
        row.idx   = '0;
        row.typed = 1'b0;
        row.want  = '0;
        return row;
    endfunction

    function automatic t_pad_row typed_row(input logic right, input logic left, input logic push,
                                           input logic [TIME_W-1:0] now, input t_res want);
        t_pad_row row;
        row = poll_row(right, left, push, now);
        row.typed = 1'b1;
        row.want  = want;
        return row;
    endfunction

    function automatic t_pad_row cfg_row(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        t_pad_row row;
        row = poll_row(1'b0, 1'b0, 1'b0, TIME_W'(data));
        row.kind = ROW_CFG;
        row.idx  = idx;
        return row;
    endfunction

    initial begin : stimulus
        t_pad_row rows[$];
        int       waited;
        pad_cfg = '{RST_SHORT_PRESS, RST_DOUBLE_CLK, RST_BEEP_LEN, RST_BEEP_VOL};
        pad = '{2'b00, 1'b0, '0, '0, 2'b00, 1'b0, '0};

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: priority, masking, clicks, double click, wrap
        rows.push_back(typed_row(0, 0, 0, 32'd0, t_res'{1'b0, KEY_NONE, 1'b0, 3'd0}));
        rows.push_back(typed_row(1, 0, 0, 32'd100, t_res'{1'b1, KEY_NEXT, 1'b0, 3'd3}));
        rows.push_back(poll_row(1, 1, 1, 32'd120));
        rows.push_back(poll_row(0, 0, 0, 32'd200));
        rows.push_back(poll_row(0, 1, 0, 32'd300));
        rows.push_back(poll_row(0, 1, 1, 32'd310));    // push hidden behind left
        rows.push_back(poll_row(0, 0, 0, 32'd400));
        rows.push_back(poll_row(0, 0, 1, 32'd1000));
        rows.push_back(poll_row(0, 0, 0, 32'd1020));   // first click stored
        rows.push_back(poll_row(0, 0, 1, 32'd1100));   // new key while beep still sounding
        rows.push_back(poll_row(0, 0, 0, 32'd1200));   // double click
        rows.push_back(poll_row(0, 0, 1, 32'd2000));
        rows.push_back(poll_row(0, 0, 0, 32'd2005));   // too short for a click
        rows.push_back(poll_row(0, 0, 1, 32'hFFFF_FFF0));
        rows.push_back(poll_row(0, 0, 0, 32'd0));      // click across the wrap, lands on zero
        rows.push_back(poll_row(0, 0, 1, 32'd100));
        rows.push_back(poll_row(0, 0, 0, 32'd200));
        rows.push_back(poll_row(0, 0, 1, 32'd300));
        rows.push_back(poll_row(0, 0, 0, 32'd650));    // gap exactly at the window edge
        rows.push_back(poll_row(1, 0, 1, 32'hFFFF_FFFF));
        // all-zero registers: silent beep, volume below range
        rows.push_back(cfg_row(CFG_SHORT_PRESS, 16'd0));
        rows.push_back(cfg_row(CFG_DOUBLE_CLK, 16'd0));
        rows.push_back(cfg_row(CFG_BEEP_LEN, 16'd0));
        rows.push_back(cfg_row(CFG_BEEP_VOL, 16'd0));
        rows.push_back(poll_row(0, 0, 0, 32'd5));
        rows.push_back(typed_row(1, 0, 0, 32'd6, t_res'{1'b1, KEY_NEXT, 1'b0, 3'd0}));
        rows.push_back(poll_row(0, 0, 1, 32'd8));
        rows.push_back(poll_row(0, 0, 0, 32'd8));
        // all-ones timing registers with volume zero (below range), then volume above range
        rows.push_back(cfg_row(CFG_SHORT_PRESS, 16'hFFFF));
        rows.push_back(cfg_row(CFG_DOUBLE_CLK, 16'hFFFF));
        rows.push_back(cfg_row(CFG_BEEP_LEN, 16'hFFFF));
        rows.push_back(cfg_row(CFG_BEEP_VOL, 16'hFFF8));
        rows.push_back(poll_row(0, 0, 0, 32'd100));
        rows.push_back(typed_row(0, 1, 0, 32'd101, t_res'{1'b1, KEY_PREV, 1'b0, 3'd1}));
        rows.push_back(cfg_row(CFG_BEEP_VOL, 16'd7));
        rows.push_back(poll_row(0, 0, 0, 32'd102));
        rows.push_back(typed_row(0, 0, 1, 32'd103, t_res'{1'b1, KEY_ENTER, 1'b0, 3'd4}));
        rows.push_back(cfg_row(CFG_BEEP_VOL, 16'd5));
        rows.push_back(poll_row(0, 0, 0, 32'd104));
        n_settings = 4;

        foreach (rows[n]) begin
            if (rows[n].kind == ROW_CFG)
                write_reg(rows[n].idx, rows[n].value[CFG_W-1:0]);
            else
                send_poll(rows[n].right, rows[n].left, rows[n].push, rows[n].value,
                          rows[n].typed, rows[n].want);
        end

        run_phase(CFG_W'($urandom_range(1, 30)), CFG_W'($urandom_range(60, 400)),
                  CFG_W'($urandom_range(5, 120)), {13'($urandom), 3'($urandom_range(0, 7))},
                  60, 32'd5000, 50);
        run_phase(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd4, 40000, $urandom, -1);
        run_phase(16'd0, 16'd0, 16'd0, 16'd1, 3, 32'd1000, -1);
        run_phase(CFG_W'($urandom_range(10, 20)), CFG_W'($urandom_range(100, 450)),
                  CFG_W'($urandom_range(30, 80)), CFG_W'($urandom_range(0, 7)),
                  50, 32'hFFFF_F000, -1);

        @(negedge i_clk);
        i_valid <= 1'b0;
        waited = 0;
        while (pad_results_due.size() != 0 && waited < 2000) begin
            @(posedge i_clk);
            waited++;
        end
        if (pad_results_due.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pad_results_due.size()));
        repeat (10) @(posedge i_clk);

        $display("%0d polls checked under %0d register settings", n_polls, n_settings);
        $display("expected %0d double clicks and %0d results with the buzzer on", n_back, n_beep);
        if (n_fail == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin : watchdog
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
